FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the grid word search checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define GWS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("gws assertion failed");

// antecedent implies consequent in the next cycle
`define GWS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("gws assertion failed");

`endif

FILE: rtl/core/gws_pkg.sv
// ----------------------------------------------------------------------------
// gws_pkg
// shared types and constants of the eight-direction grid word search
// ----------------------------------------------------------------------------
package gws_pkg;

  localparam int MaxGrid   = 16;
  localparam int MaxWord   = 16;
  localparam int CoordW    = (MaxGrid > 1) ? $clog2(MaxGrid) : 1;
  localparam int SizeW     = $clog2(MaxGrid + 1);
  localparam int LenW      = $clog2(MaxWord + 1);
  localparam int IdxW      = (MaxWord > 1) ? $clog2(MaxWord) : 1;
  localparam int CellCount = MaxGrid * MaxGrid;
  localparam int AddrW     = $clog2(CellCount);
  localparam int SpanW     = ((CoordW > LenW) ? CoordW : LenW) + 2;

  localparam int LetterW   = 8;
  localparam int FieldW    = 4;
  localparam int CfgW      = 5;
  localparam logic [CfgW-1:0] GridSizeReset = CfgW'(9);

  localparam int NumDir = 8;
  localparam int DirW   = 3;

  // operation codes
  localparam logic OpLoad = 1'b0;
  localparam logic OpWord = 1'b1;

  // steps in search order: right, left, up, down, up-left, up-right,
  // down-left, down-right
  localparam logic signed [1:0] DirDx [NumDir] = '{
    2'sd1, -2'sd1, 2'sd0, 2'sd0, -2'sd1, 2'sd1, -2'sd1, 2'sd1
  };
  localparam logic signed [1:0] DirDy [NumDir] = '{
    2'sd0, 2'sd0, -2'sd1, 2'sd1, -2'sd1, -2'sd1, 2'sd1, 2'sd1
  };

  typedef struct packed {
    logic              operation;
    logic [LetterW-1:0] letter;
    logic [FieldW-1:0] cell_row;
    logic [FieldW-1:0] cell_col;
    logic              last_letter;
  } in_item_t;

  typedef struct packed {
    logic              found;
    logic [FieldW-1:0] start_col;
    logic [FieldW-1:0] start_row;
  } res_item_t;

endpackage

FILE: rtl/core/gws_intf.sv
// ----------------------------------------------------------------------------
// gws channel interfaces
// valid/ready channels for items, results and the grid size register
// ----------------------------------------------------------------------------
interface gws_in_if import gws_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface gws_res_if import gws_pkg::*; ();
  logic      valid;
  logic      ready;
  res_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface gws_cfg_if import gws_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CfgW-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/gws_ram.sv
// ----------------------------------------------------------------------------
// gws_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module gws_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/core/grid_word_search_eight_dir_core.sv
// ----------------------------------------------------------------------------
// grid_word_search_eight_dir_core
// eight-direction word search over a square letter grid held in ram
// ----------------------------------------------------------------------------
//  channel  dir  payload                                   transfer when
//  in_i     in   operation letter cell_row cell_col last   valid & ready
//  res_o    out  found start_col start_row                 valid & ready
//  cfg_i    in   grid_size                                 valid & ready
//
//  loads and non-final word letters are only stored, no search runs
//  a final letter runs the search: ST_DIR per direction tried, then ST_RD and
//  ST_CMP per letter compared (ram address, then compare on registered data)
//  the grid ram has a single read port, so letters are read one at a time
//  reset clears control only; grid and word storage are undefined until written
// ----------------------------------------------------------------------------
module grid_word_search_eight_dir_core import gws_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  gws_in_if.sink   in_i,
  gws_res_if.source res_o,
  gws_cfg_if.sink  cfg_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIR,
    ST_RD,
    ST_CMP,
    ST_FIN
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [CfgW-1:0] grid_size_q;

  // word buffer
  logic [LetterW-1:0] word_q [MaxWord];
  logic [LenW-1:0]    len_q, len_d;
  logic               long_q, long_d;

  // search position
  logic [SizeW-1:0]  n_q, n_d;
  logic [CoordW-1:0] x_q, x_d, y_q, y_d;
  logic [CoordW-1:0] cx_q, cx_d, cy_q, cy_d;
  logic [DirW-1:0]   d_q, d_d;
  logic [IdxW-1:0]   i_q, i_d;

  // result register
  logic      res_valid_q, res_valid_d;
  res_item_t res_q, res_d;
  logic      hit_q, hit_d;

  // ram
  logic               ram_we;
  logic [AddrW-1:0]   ram_waddr, ram_raddr;
  logic [LetterW-1:0] ram_rdata;

  logic in_xfer, word_wr;
  logic [SizeW-1:0] n_clamp;

  // bounds check of the far end of the word
  logic signed [SpanW-1:0] span, base_x, base_y, end_x, end_y, n_s;
  logic                    dir_ok;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign res_o.valid = res_valid_q;
  assign res_o.data  = res_q;

  assign in_xfer = in_i.valid & in_i.ready;
  assign word_wr = in_xfer && (in_i.data.operation == OpWord) && (int'(len_q) < MaxWord);

  assign ram_we    = in_xfer && (in_i.data.operation == OpLoad)
                     && (int'(in_i.data.cell_row) < MaxGrid)
                     && (int'(in_i.data.cell_col) < MaxGrid);
  assign ram_waddr = AddrW'(int'(in_i.data.cell_row) * MaxGrid + int'(in_i.data.cell_col));
  assign ram_raddr = AddrW'(int'(cy_q) * MaxGrid + int'(cx_q));

  // sizes above storage clamp to the storage side
  assign n_clamp = (int'(grid_size_q) > MaxGrid) ? SizeW'(MaxGrid) : SizeW'(grid_size_q);

  assign span   = SpanW'(len_q) - SpanW'(1);
  assign base_x = SpanW'(x_q);
  assign base_y = SpanW'(y_q);
  assign n_s    = SpanW'(n_q);

  always_comb begin
    case (DirDx[d_q])
      2'sd1:   end_x = base_x + span;
      -2'sd1:  end_x = base_x - span;
      default: end_x = base_x;
    endcase
    case (DirDy[d_q])
      2'sd1:   end_y = base_y + span;
      -2'sd1:  end_y = base_y - span;
      default: end_y = base_y;
    endcase
    dir_ok = (end_x >= 0) && (end_x < n_s) && (end_y >= 0) && (end_y < n_s);
  end

  gws_ram #(
    .Width (LetterW),
    .Depth (CellCount)
  ) u_grid_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (in_i.data.letter),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // sequencer
  always_comb begin
    logic            adv;
    logic [LenW-1:0] len_new;
    logic            long_new;

    state_d     = state_q;
    len_d       = len_q;
    long_d      = long_q;
    n_d         = n_q;
    x_d         = x_q;
    y_d         = y_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    d_d         = d_q;
    i_d         = i_q;
    hit_d       = hit_q;
    res_d       = res_q;
    res_valid_d = res_valid_q;
    adv         = 1'b0;
    len_new     = len_q;
    long_new    = long_q;

    // result leaves on transfer
    if (res_valid_q && res_o.ready) begin
      res_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_xfer && (in_i.data.operation == OpWord)) begin
          if (int'(len_q) < MaxWord) begin
            len_new = len_q + LenW'(1);
          end else begin
            long_new = 1'b1;
          end
          len_d  = len_new;
          long_d = long_new;
          if (in_i.data.last_letter) begin
            n_d   = n_clamp;
            x_d   = '0;
            y_d   = '0;
            d_d   = '0;
            hit_d = 1'b0;
            // overlong word or empty grid: straight to not found
            if (long_new || (n_clamp == '0)) begin
              state_d = ST_FIN;
            end else begin
              state_d = ST_DIR;
            end
          end
        end
      end
      ST_DIR: begin
        if (dir_ok) begin
          cx_d    = x_q;
          cy_d    = y_q;
          i_d     = '0;
          state_d = ST_RD;
        end else begin
          adv = 1'b1;
        end
      end
      ST_RD: begin
        state_d = ST_CMP;
      end
      ST_CMP: begin
        if (ram_rdata != word_q[i_q]) begin
          adv = 1'b1;
        end else if (LenW'(i_q) + LenW'(1) == len_q) begin
          hit_d   = 1'b1;
          state_d = ST_FIN;
        end else begin
          i_d     = i_q + IdxW'(1);
          cx_d    = cx_q + CoordW'(DirDx[d_q]);
          cy_d    = cy_q + CoordW'(DirDy[d_q]);
          state_d = ST_RD;
        end
      end
      ST_FIN: begin
        if (!res_valid_q || res_o.ready) begin
          res_valid_d     = 1'b1;
          res_d.found     = hit_q;
          res_d.start_col = hit_q ? FieldW'(x_q) : '0;
          res_d.start_row = hit_q ? FieldW'(y_q) : '0;
          len_d           = '0;
          long_d          = 1'b0;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // next direction, then next start cell in raster order
    if (adv) begin
      state_d = ST_DIR;
      if (d_q == DirW'(NumDir - 1)) begin
        d_d = '0;
        if (SizeW'(x_q) + SizeW'(1) == n_q) begin
          x_d = '0;
          if (SizeW'(y_q) + SizeW'(1) == n_q) begin
            state_d = ST_FIN;
          end else begin
            y_d = y_q + CoordW'(1);
          end
        end else begin
          x_d = x_q + CoordW'(1);
        end
      end else begin
        d_d = d_q + DirW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      grid_size_q <= GridSizeReset;
      len_q       <= '0;
      long_q      <= 1'b0;
      res_valid_q <= 1'b0;
      n_q         <= '0;
      x_q         <= '0;
      y_q         <= '0;
      d_q         <= '0;
      i_q         <= '0;
      cx_q        <= '0;
      cy_q        <= '0;
      hit_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      long_q      <= long_d;
      res_valid_q <= res_valid_d;
      n_q         <= n_d;
      x_q         <= x_d;
      y_q         <= y_d;
      d_q         <= d_d;
      i_q         <= i_d;
      cx_q        <= cx_d;
      cy_q        <= cy_d;
      hit_q       <= hit_d;
      if (cfg_i.valid && cfg_i.ready) begin
        grid_size_q <= cfg_i.data;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (word_wr) begin
      word_q[len_q[IdxW-1:0]] <= in_i.data.letter;
    end
  end

endmodule

FILE: rtl/core/gws_chk.sv
// ----------------------------------------------------------------------------
// gws_chk
// port-level checks of the grid word search, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gws_chk import gws_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_i,
  input logic      in_op_i,
  input logic      in_last_i,
  input logic      res_valid_i,
  input logic      res_ready_i,
  input res_item_t res_data_i
);

  logic in_xfer;
  assign in_xfer = in_valid_i & in_ready_i;

  // a stalled result holds
  `GWS_ASSERT_NEXT(a_res_hold, clk_i, rst_ni, res_valid_i && !res_ready_i, res_valid_i && $stable(res_data_i))

  // no match reports the origin
  `GWS_ASSERT_SAME(a_miss_zero, clk_i, rst_ni, res_valid_i && !res_data_i.found, (res_data_i.start_col == '0) && (res_data_i.start_row == '0))

  // a final word letter starts the search and blocks input
  `GWS_ASSERT_NEXT(a_last_busy, clk_i, rst_ni, in_xfer && (in_op_i == OpWord) && in_last_i, !in_ready_i)

  // a grid load never produces a result
  `GWS_ASSERT_NEXT(a_load_quiet, clk_i, rst_ni, in_xfer && (in_op_i == OpLoad) && !res_valid_i, !res_valid_i)

endmodule

bind grid_word_search_eight_dir_core gws_chk u_gws_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_op_i     (in_i.data.operation),
  .in_last_i   (in_i.data.last_letter),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_data_i  (res_o.data)
);

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the eight-direction grid word search core: grid
// loads and words are driven over the item channel, each search result is
// checked against a predictor kept in the bench, under random stalls on
// both sides and several grid sizes
// ----------------------------------------------------------------------------
module tb_top;
  import gws_pkg::*;

  // run shape
  localparam int TargetItems  = 1900;
  localparam int MaxGap       = 12;
  localparam int StallLimit   = 300000;  // watchdog bound, above the worst search at size 16
  localparam int SettleCycles = 16;
  localparam int TailCycles   = 64;
  localparam int NumDirs      = 8;
  localparam logic [LetterW-1:0] AlphaBase = 8'h41;

  // search directions in the order the core tries them
  typedef enum int {
    DirRight, DirLeft, DirUp, DirDown, DirUpLeft, DirUpRight, DirDownLeft, DirDownRight
  } dir_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  gws_in_if  in_if ();
  gws_res_if res_if ();
  gws_cfg_if cfg_if ();

  grid_word_search_eight_dir_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // predictor state: own copy of grid, word buffer and grid size register
  // --------------------------------------------------------------------------
  logic [LetterW-1:0] grid_m [CellCount];
  logic [LetterW-1:0] word_m [MaxWord];
  int                 word_len_m;
  bit                 word_over_m;
  logic [CfgW-1:0]    grid_size_m;

  res_item_t          search_q [$];  // expected search results, oldest first
  logic [LetterW-1:0] word_buf [$];  // letters of the next word to send

  bit src_idle;
  bit snk_idle;
  int fail_count;
  int items_sent;
  int searches;
  int hits;
  int overlong_words;
  int size_writes;

  function automatic int step_x(int d);
    case (d)
      DirRight, DirUpRight, DirDownRight: return 1;
      DirLeft, DirUpLeft, DirDownLeft:    return -1;
      default:                            return 0;
    endcase
  endfunction

  function automatic int step_y(int d);
    case (d)
      DirDown, DirDownLeft, DirDownRight: return 1;
      DirUp, DirUpLeft, DirUpRight:       return -1;
      default:                            return 0;
    endcase
  endfunction

  // does the held word start at column x, row y in some direction that fits
  function automatic bit match_at(int x, int y, int n, int len);
    int d, i, ex, ey, cx, cy;
    bit ok;
    if (grid_m[y * MaxGrid + x] != word_m[0]) return 1'b0;
    if (len == 1) return 1'b1;
    for (d = 0; d < NumDirs; d++) begin
      ex = x + step_x(d) * (len - 1);
      ey = y + step_y(d) * (len - 1);
      if (ex < 0 || ex >= n || ey < 0 || ey >= n) continue;
      ok = 1'b1;
      for (i = 1; i < len; i++) begin
        cx = x + step_x(d) * i;
        cy = y + step_y(d) * i;
        if (grid_m[cy * MaxGrid + cx] != word_m[i]) begin
          ok = 1'b0;
          break;
        end
      end
      if (ok) return 1'b1;
    end
    return 1'b0;
  endfunction

  // apply one accepted item to the predictor, queue a result on a final letter
  function automatic void predict_item(in_item_t it);
    int n, x, y;
    bit hit;
    res_item_t r;
    if (it.operation == OpLoad) begin
      grid_m[{it.cell_row, it.cell_col}] = it.letter;
      return;
    end
    if (word_len_m < MaxWord) begin
      word_m[word_len_m] = it.letter;
      word_len_m++;
    end else begin
      word_over_m = 1'b1;
    end
    if (!it.last_letter) return;
    n = (int'(grid_size_m) > MaxGrid) ? MaxGrid : int'(grid_size_m);
    r = '0;
    hit = 1'b0;
    // raster scan, first start cell wins
    if (!word_over_m && word_len_m > 0) begin
      for (y = 0; y < n && !hit; y++) begin
        for (x = 0; x < n && !hit; x++) begin
          if (match_at(x, y, n, word_len_m)) begin
            hit = 1'b1;
            r.found = 1'b1;
            r.start_col = FieldW'(x);
            r.start_row = FieldW'(y);
          end
        end
      end
    end
    search_q.push_back(r);
    searches++;
    if (hit) hits++;
    if (word_over_m) overlong_words++;
    word_len_m = 0;
    word_over_m = 1'b0;
  endfunction

  // --------------------------------------------------------------------------
  // item helpers
  // --------------------------------------------------------------------------
  function automatic logic [LetterW-1:0] pick_letter();
    // mostly a small alphabet so that words hit, sometimes any code
    if ($urandom_range(0, 4) == 0) return LetterW'($urandom);
    return AlphaBase + LetterW'($urandom_range(0, 3));
  endfunction

  function automatic in_item_t load_item(int row, int col, logic [LetterW-1:0] l);
    in_item_t it;
    it.operation   = OpLoad;
    it.letter      = l;
    it.cell_row    = FieldW'(row);
    it.cell_col    = FieldW'(col);
    it.last_letter = 1'($urandom_range(0, 1));  // ignored on loads
    return it;
  endfunction

  function automatic in_item_t word_item(logic [LetterW-1:0] l, bit last);
    in_item_t it;
    it.operation   = OpWord;
    it.letter      = l;
    it.cell_row    = FieldW'($urandom);  // row and column ignored on word letters
    it.cell_col    = FieldW'($urandom);
    it.last_letter = last;
    return it;
  endfunction

  // longest word that fits from column x, row y in direction d
  function automatic int fit_len(int x, int y, int d, int n);
    int k;
    k = MaxWord;
    if (step_x(d) > 0 && n - x < k) k = n - x;
    if (step_x(d) < 0 && x + 1 < k) k = x + 1;
    if (step_y(d) > 0 && n - y < k) k = n - y;
    if (step_y(d) < 0 && y + 1 < k) k = y + 1;
    return k;
  endfunction

  // word read off the predictor grid along a line
  function automatic void build_line(int x, int y, int d, int len);
    int i;
    word_buf.delete();
    for (i = 0; i < len; i++)
      word_buf.push_back(grid_m[(y + step_y(d) * i) * MaxGrid + x + step_x(d) * i]);
  endfunction

  function automatic void build_random(int len);
    int i;
    word_buf.delete();
    for (i = 0; i < len; i++) word_buf.push_back(pick_letter());
  endfunction

  // one item over the input channel, with a random gap before it while src_idle is set
  task automatic send_item(in_item_t it);
    int gap;
    gap = src_idle ? $urandom_range(0, MaxGap) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    do @(posedge clk_i); while (!in_if.ready);
    predict_item(it);
    items_sent++;
  endtask

  // send word_buf, optionally with grid loads slipped in between letters
  task automatic send_word(bit noisy);
    int i;
    for (i = 0; i < word_buf.size(); i++) begin
      if (noisy && $urandom_range(0, 3) == 0)
        send_item(load_item($urandom_range(0, MaxGrid - 1), $urandom_range(0, MaxGrid - 1),
                            pick_letter()));
      send_item(word_item(word_buf[i], i == word_buf.size() - 1));
    end
  endtask

  // drop valid, let every pending search come back, then settle
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (search_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_grid_size(logic [CfgW-1:0] v);
    wait_idle();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= v;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    grid_size_m = v;
    size_writes++;
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // every cell written once so that no search reads an unloaded cell
  task automatic test_preload();
    int r, c;
    src_idle = 1'b0;
    for (r = 0; r < MaxGrid; r++)
      for (c = 0; c < MaxGrid; c++) send_item(load_item(r, c, pick_letter()));
  endtask

  // distinct letters in a 3x3 grid, a two-letter word from the centre each way
  task automatic test_directions();
    int r, c, d;
    src_idle = 1'b1;
    snk_idle = 1'b1;
    write_grid_size(CfgW'(3));
    for (r = 0; r < 3; r++)
      for (c = 0; c < 3; c++) send_item(load_item(r, c, 8'h61 + LetterW'(r * 3 + c)));
    for (d = 0; d < NumDirs; d++) begin
      build_line(1, 1, d, 2);
      send_word(1'b0);
    end
  endtask

  // grid size zero, one, and above the storage size; letter extremes
  task automatic test_size_extremes();
    src_idle = 1'b0;
    snk_idle = 1'b0;
    write_grid_size(CfgW'(0));
    build_line(0, 0, DirRight, 1);
    send_word(1'b0);
    write_grid_size(CfgW'(1));
    build_line(0, 0, DirRight, 1);  // one-letter word on the only cell
    send_word(1'b0);
    build_random(0);
    word_buf.push_back(8'h00);
    send_word(1'b0);
    build_random(0);
    word_buf.push_back(8'hFF);
    send_word(1'b0);
    write_grid_size(CfgW'(31));     // taken as the full grid
    send_item(load_item(MaxGrid - 1, MaxGrid - 1, 8'hFF));
    build_line(MaxGrid - 1, MaxGrid - 1, DirUpLeft, 2);
    send_word(1'b0);
  endtask

  // a word past the buffer length is not found, and the next word is clean
  task automatic test_overlong();
    src_idle = 1'b1;
    snk_idle = 1'b0;
    write_grid_size(CfgW'(4));
    build_line(0, 0, DirRight, 4);
    while (word_buf.size() < MaxWord + 1) word_buf.push_back(pick_letter());
    send_word(1'b0);
    build_line(1, 1, DirDown, 2);
    send_word(1'b0);
  endtask

  // random phases: a grid size, some loads, then mostly words read off the grid
  task automatic test_random();
    int phase, r, n, cap, k, i, w, kind, x, y, d, len;
    logic [CfgW-1:0] sz;
    phase = 0;
    while (items_sent < TargetItems) begin
      r = $urandom_range(0, 24);
      if (phase == 0) begin
        sz = CfgW'(MaxGrid);
      end else begin
        case (r)
          0:       sz = CfgW'(0);
          1:       sz = CfgW'(MaxGrid);
          2:       sz = CfgW'($urandom_range(MaxGrid + 1, 31));
          3:       sz = CfgW'(1);
          default: sz = CfgW'($urandom_range(2, 6));
        endcase
      end
      write_grid_size(sz);
      src_idle = ($urandom_range(0, 3) != 0);
      snk_idle = ($urandom_range(0, 3) != 0);
      n = (int'(sz) > MaxGrid) ? MaxGrid : int'(sz);
      // big grids are slow to search, keep their words short
      cap = (n == MaxGrid) ? 3 : 6;

      k = $urandom_range(0, 2 * n + 2);
      for (i = 0; i < k; i++) begin
        if (n > 0 && $urandom_range(0, 3) != 0)
          send_item(load_item($urandom_range(0, n - 1), $urandom_range(0, n - 1),
                              pick_letter()));
        else
          send_item(load_item($urandom_range(0, MaxGrid - 1), $urandom_range(0, MaxGrid - 1),
                              pick_letter()));
      end

      // a word of the full buffer length along one row, now and then
      if (n == MaxGrid && (phase == 0 || $urandom_range(0, 2) == 0)) begin
        build_line(0, $urandom_range(0, MaxGrid - 1), DirRight, MaxWord);
        send_word(1'b0);
      end

      w = $urandom_range(2, 6);
      for (i = 0; i < w; i++) begin
        kind = $urandom_range(0, 9);
        if (n > 0 && (kind <= 5 || kind == 9)) begin
          x = $urandom_range(0, n - 1);
          y = $urandom_range(0, n - 1);
          d = $urandom_range(0, NumDirs - 1);
          len = fit_len(x, y, d, n);
          if (len > cap) len = cap;
          len = $urandom_range(1, len);
          build_line(x, y, d, len);
          if ($urandom_range(0, 4) == 0) word_buf[$urandom_range(0, len - 1)] = pick_letter();
          send_word(kind == 9 || $urandom_range(0, 9) == 0);
        end else if (kind == 8 && n <= 6) begin
          build_random($urandom_range(MaxWord + 1, MaxWord + 4));
          send_word(1'b0);
        end else begin
          build_random($urandom_range(1, cap));
          send_word(1'b0);
        end
      end
      phase++;
    end
  endtask

  // --------------------------------------------------------------------------
  // result side: random ready stalls and the field-by-field check
  // --------------------------------------------------------------------------
  function automatic int sink_gap();
    return snk_idle ? $urandom_range(0, MaxGap) : 0;
  endfunction

  initial begin
    int hold;
    res_item_t want;
    res_if.ready <= 1'b0;
    hold = 1;
    forever begin
      @(posedge clk_i);
      if (res_if.valid && res_if.ready) begin
        if (search_q.size() == 0) begin
          $error("result with no search pending: found %0d col %0d row %0d",
                 res_if.data.found, res_if.data.start_col, res_if.data.start_row);
          fail_count++;
        end else begin
          want = search_q.pop_front();
          if (res_if.data.found !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, res_if.data.found);
            fail_count++;
          end
          if (res_if.data.start_col !== want.start_col) begin
            $error("start_col: expected %0d, actual %0d", want.start_col,
                   res_if.data.start_col);
            fail_count++;
          end
          if (res_if.data.start_row !== want.start_row) begin
            $error("start_row: expected %0d, actual %0d", want.start_row,
                   res_if.data.start_row);
            fail_count++;
          end
        end
        hold = sink_gap();
        res_if.ready <= (hold == 0);
      end else if (!res_if.ready) begin
        if (hold > 0) hold--;
        if (hold == 0) res_if.ready <= 1'b1;
      end
    end
  end

  // watchdog: too long without any transfer on any channel
  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("timeout after %0d cycles without a transfer", StallLimit);
      $display("Some tests failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // sequence
  // --------------------------------------------------------------------------
  initial begin
    in_if.valid  <= 1'b0;
    in_if.data   <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data  <= '0;
    word_len_m   = 0;
    word_over_m  = 1'b0;
    grid_size_m  = GridSizeReset;
    src_idle     = 1'b0;
    snk_idle     = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_preload();
    test_directions();
    test_size_extremes();
    test_overlong();
    test_random();

    wait_idle();
    repeat (TailCycles) @(posedge clk_i);
    if (search_q.size() != 0) begin
      $error("%0d searches never answered", search_q.size());
      fail_count++;
    end
    $display("covered %0d items, %0d searches (%0d found, %0d overlong words)",
             items_sent, searches, hits, overlong_words);
    $display("grid size written %0d times, sizes 0 to 31 with idle and stall mixes",
             size_writes);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/gws_pkg.sv
rtl/core/gws_intf.sv
rtl/core/gws_ram.sv
rtl/core/grid_word_search_eight_dir_core.sv
rtl/core/gws_chk.sv
verif/tb_top.sv
